>>> rtl/polyint_pkg.sv
package polyint_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int COEF_IDX_W  = 7;
    localparam int PHASE_IDX_W = 4;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic [COEF_IDX_W-1:0]      coef_idx_t;
    typedef logic [PHASE_IDX_W-1:0]     phase_idx_t;

    // Request command codes.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_PUSH = 1'b1;

endpackage

>>> rtl/polyint_ram.sv
module polyint_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/polyphase_interpolator.sv
// Polyphase FIR interpolator for complex Q1.15 samples.
// Input channel (s_*): a request with s_command = CMD_LOAD writes s_coef_value into the
// coefficient store at s_coef_index (phase + tap*PHASES); indexes beyond the kernel are
// dropped. A load produces no result and leaves s_ready high. A request with
// s_command = CMD_PUSH writes the complex sample into the delay line and produces
// PHASES results on the output channel (m_*), in phase order, m_last on the final one.
// Each result is one multiply-accumulate per tap through a single complex-by-real MAC,
// with the delay line and the coefficients read from two simple dual-port RAMs. A phase
// issues every tap read in ST_RUN, then drains through the RAM read, the product register
// and the accumulator in ST_DRAIN before its result is loaded. s_ready is high only while
// no push is in progress. The result register holds a finished output while the next
// phase is computed; if the receiver still stalls when that phase finishes, the engine
// waits. Reset clears the write pointer and marks every delay-line entry empty (read as
// zero); the coefficient store is not cleared and must be loaded before use.
module polyphase_interpolator #(
    parameter int TAPS_PER_PHASE = 32,
    parameter int PHASES         = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_command,
    input  polyint_pkg::coef_idx_t s_coef_index,
    input  polyint_pkg::coef_t     s_coef_value,
    input  polyint_pkg::sample_t   s_sample_re,
    input  polyint_pkg::sample_t   s_sample_im,
    output logic                   m_valid,
    input  logic                   m_ready,
    output polyint_pkg::sample_t   m_out_re,
    output polyint_pkg::sample_t   m_out_im,
    output polyint_pkg::phase_idx_t m_phase_index,
    output logic                   m_last
);

    import polyint_pkg::*;

    localparam int KERNEL_LEN = PHASES * TAPS_PER_PHASE;
    localparam int TAP_W      = TAPS_PER_PHASE > 1 ? $clog2(TAPS_PER_PHASE) : 1;
    localparam int PH_W       = PHASES > 1 ? $clog2(PHASES) : 1;
    localparam int KER_W      = KERNEL_LEN > 1 ? $clog2(KERNEL_LEN) : 1;
    localparam int ACC_W      = 2 * SAMPLE_W + 1 + $clog2(TAPS_PER_PHASE);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [TAP_W-1:0] wp_reg, wp_next;
    logic [TAP_W-1:0] tap_reg, tap_next;
    logic [TAP_W-1:0] daddr_reg, daddr_next;
    logic [KER_W-1:0] caddr_reg, caddr_next;
    logic [PH_W-1:0]  phase_reg, phase_next;
    logic [TAPS_PER_PHASE-1:0] dvalid_reg, dvalid_next;

    // Pipeline: issue -> RAM data (stage 1) -> products (stage 2) -> accumulator.
    logic s1_vld_reg, s1_first_reg, s1_last_reg, s1_zero_reg;
    logic s2_vld_reg, s2_first_reg, s2_last_reg;
    logic signed [2*SAMPLE_W-1:0] prod_re_reg, prod_im_reg;
    logic signed [2*SAMPLE_W-1:0] prod_re_next, prod_im_next;
    logic signed [ACC_W-1:0] acc_re_reg, acc_im_reg;
    logic done_reg, done_next;

    logic       m_valid_reg, m_valid_next;
    sample_t    out_re_reg, out_im_reg;
    phase_idx_t out_phase_reg;
    logic       out_last_reg;

    logic issue;
    logic out_load;
    logic push_acc;
    logic load_acc;
    logic coef_we;

    logic [2*SAMPLE_W-1:0] dl_rdata;
    logic [COEF_W-1:0]     coef_rdata;
    sample_t               dre, dim;

    function automatic sample_t round_sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W:0] r;
        r = $signed({a[ACC_W-1], a}) + $signed((ACC_W+1)'(16384));
        r = r >>> 15;
        if (r > $signed((ACC_W+1)'(32767))) begin
            return 16'sh7FFF;
        end else if (r < -$signed((ACC_W+1)'(32768))) begin
            return 16'sh8000;
        end
        return r[SAMPLE_W-1:0];
    endfunction

    assign s_ready  = (state_reg == ST_IDLE);
    assign push_acc = s_valid && s_ready && (s_command == CMD_PUSH);
    assign load_acc = s_valid && s_ready && (s_command == CMD_LOAD);
    assign coef_we  = load_acc && (32'(s_coef_index) < 32'(KERNEL_LEN));
    assign issue    = (state_reg == ST_RUN);
    assign out_load = (state_reg == ST_DRAIN) && done_reg && (!m_valid_reg || m_ready);

    polyint_ram #(
        .WIDTH(2 * SAMPLE_W),
        .DEPTH(TAPS_PER_PHASE)
    ) u_delay_ram (
        .aclk (aclk),
        .we   (push_acc),
        .waddr(wp_reg),
        .wdata({s_sample_re, s_sample_im}),
        .raddr(daddr_reg),
        .rdata(dl_rdata)
    );

    polyint_ram #(
        .WIDTH(COEF_W),
        .DEPTH(KERNEL_LEN)
    ) u_coef_ram (
        .aclk (aclk),
        .we   (coef_we),
        .waddr(KER_W'(s_coef_index)),
        .wdata(s_coef_value),
        .raddr(caddr_reg),
        .rdata(coef_rdata)
    );

    // An entry never written since reset reads as zero.
    assign dre = s1_zero_reg ? '0 : sample_t'(dl_rdata[2*SAMPLE_W-1:SAMPLE_W]);
    assign dim = s1_zero_reg ? '0 : sample_t'(dl_rdata[SAMPLE_W-1:0]);
    assign prod_re_next = dre * $signed(coef_rdata);
    assign prod_im_next = dim * $signed(coef_rdata);

    always_comb begin
        state_next   = state_reg;
        wp_next      = wp_reg;
        tap_next     = tap_reg;
        daddr_next   = daddr_reg;
        caddr_next   = caddr_reg;
        phase_next   = phase_reg;
        dvalid_next  = dvalid_reg;
        done_next    = done_reg;
        m_valid_next = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (s2_vld_reg && s2_last_reg) begin
            done_next = 1'b1;
        end

        case (state_reg)
            ST_IDLE: begin
                if (push_acc) begin
                    dvalid_next[wp_reg] = 1'b1;
                    state_next = ST_RUN;
                    tap_next   = '0;
                    phase_next = '0;
                    daddr_next = wp_reg;
                    caddr_next = '0;
                end
            end
            ST_RUN: begin
                tap_next   = tap_reg + TAP_W'(1);
                daddr_next = (daddr_reg == '0) ? TAP_W'(TAPS_PER_PHASE - 1)
                                               : daddr_reg - TAP_W'(1);
                caddr_next = caddr_reg + KER_W'(PHASES);
                if (tap_reg == TAP_W'(TAPS_PER_PHASE - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_load) begin
                    done_next    = 1'b0;
                    m_valid_next = 1'b1;
                    if (phase_reg == PH_W'(PHASES - 1)) begin
                        state_next = ST_IDLE;
                        wp_next    = (wp_reg == TAP_W'(TAPS_PER_PHASE - 1)) ? '0
                                                                            : wp_reg + TAP_W'(1);
                    end else begin
                        state_next = ST_RUN;
                        phase_next = phase_reg + PH_W'(1);
                        tap_next   = '0;
                        daddr_next = wp_reg;
                        caddr_next = KER_W'(phase_reg) + KER_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wp_reg      <= '0;
            dvalid_reg  <= '0;
            done_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            tap_reg     <= '0;
            phase_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            dvalid_reg  <= dvalid_next;
            done_reg    <= done_next;
            m_valid_reg <= m_valid_next;
            s1_vld_reg  <= issue;
            s2_vld_reg  <= s1_vld_reg;
            tap_reg     <= tap_next;
            phase_reg   <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        daddr_reg    <= daddr_next;
        caddr_reg    <= caddr_next;
        s1_first_reg <= (tap_reg == '0);
        s1_last_reg  <= (tap_reg == TAP_W'(TAPS_PER_PHASE - 1));
        s1_zero_reg  <= !dvalid_reg[daddr_reg];
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        prod_re_reg  <= prod_re_next;
        prod_im_reg  <= prod_im_next;
        if (s2_vld_reg) begin
            if (s2_first_reg) begin
                acc_re_reg <= ACC_W'(prod_re_reg);
                acc_im_reg <= ACC_W'(prod_im_reg);
            end else begin
                acc_re_reg <= acc_re_reg + ACC_W'(prod_re_reg);
                acc_im_reg <= acc_im_reg + ACC_W'(prod_im_reg);
            end
        end
        if (out_load) begin
            out_re_reg    <= round_sat(acc_re_reg);
            out_im_reg    <= round_sat(acc_im_reg);
            out_phase_reg <= PHASE_IDX_W'(phase_reg);
            out_last_reg  <= (phase_reg == PH_W'(PHASES - 1));
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_re      = out_re_reg;
    assign m_out_im      = out_im_reg;
    assign m_phase_index = out_phase_reg;
    assign m_last        = out_last_reg;

endmodule

>>> rtl/polyint_checker.sv
module polyint_checker #(
    parameter int PHASES = 4
) (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    s_command,
    input logic                    m_valid,
    input logic                    m_ready,
    input polyint_pkg::sample_t    m_out_re,
    input polyint_pkg::sample_t    m_out_im,
    input polyint_pkg::phase_idx_t m_phase_index,
    input logic                    m_last
);

    import polyint_pkg::*;

    // No result is shown in the cycle after reset.
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_re) && $stable(m_out_im)
            && $stable(m_phase_index) && $stable(m_last))
        else $error("stalled result changed");

    // The final phase, and only it, carries the last mark.
    a_last_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (m_phase_index == PHASE_IDX_W'(PHASES - 1))))
        else $error("last mark does not match phase index");

    // A sample request occupies the engine; a coefficient load does not.
    a_push_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_command == CMD_PUSH |=> !s_ready)
        else $error("input ready right after a sample request");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_command == CMD_LOAD |=> s_ready)
        else $error("input not ready after a coefficient load");

endmodule

bind polyphase_interpolator polyint_checker #(
    .PHASES(PHASES)
) u_polyint_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_command    (s_command),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_re     (m_out_re),
    .m_out_im     (m_out_im),
    .m_phase_index(m_phase_index),
    .m_last       (m_last)
);

>>> test/polyphase_interpolator_tb.sv
`timescale 1ns / 100ps

module polyphase_interpolator_tb;
    import polyint_pkg::*;

    localparam int TAPS       = 32;
    localparam int PHASES     = 4;
    localparam int KERNEL_LEN = TAPS * PHASES;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic      command;
        coef_idx_t coef_index;
        coef_t     coef_value;
        sample_t   sample_re;
        sample_t   sample_im;
        bit        wait_for_drain;
        bit        no_gap;
    } interp_req_t;

    typedef struct {
        sample_t    out_re;
        sample_t    out_im;
        phase_idx_t phase_index;
        logic       last;
    } branch_out_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_command = CMD_LOAD;
    coef_idx_t  s_coef_index = '0;
    coef_t      s_coef_value = '0;
    sample_t    s_sample_re = '0;
    sample_t    s_sample_im = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    sample_t    m_out_re;
    sample_t    m_out_im;
    phase_idx_t m_phase_index;
    logic       m_last;

    interp_req_t requests_todo[$];
    branch_out_t branch_outputs_due[$];

    // Predictor state: kernel, complex delay line and its write pointer.
    coef_t   kernel[KERNEL_LEN];
    sample_t line_re[TAPS];
    sample_t line_im[TAPS];
    int      line_ptr = 0;

    int unsigned queued_total = 0;
    int unsigned accepted_total = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    bit          calm_stretch = 1'b0;

    polyphase_interpolator #(
        .TAPS_PER_PHASE(TAPS),
        .PHASES        (PHASES)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_coef_index (s_coef_index),
        .s_coef_value (s_coef_value),
        .s_sample_re  (s_sample_re),
        .s_sample_im  (s_sample_im),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_re     (m_out_re),
        .m_out_im     (m_out_im),
        .m_phase_index(m_phase_index),
        .m_last       (m_last)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Mostly short pauses, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 3);
        if (r < 92) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'h8000;
        if (r < 20) return 16'h7fff;
        if (r < 50) return 16'($urandom_range(0, 4095) - 2048);
        return 16'($urandom);
    endfunction

    // Round half up from sums of Q2.30 products to Q1.15, then saturate.
    function automatic sample_t round_to_q15(longint acc);
        longint q;
        q = (acc + 64'sd16384) >>> 15;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return sample_t'(q);
    endfunction

    function automatic void predict_request(interp_req_t r);
        longint      acc_re;
        longint      acc_im;
        int          pos;
        branch_out_t o;
        if (r.command == CMD_LOAD) begin
            kernel[r.coef_index] = r.coef_value;
            return;
        end
        line_re[line_ptr] = r.sample_re;
        line_im[line_ptr] = r.sample_im;
        for (int ph = 0; ph < PHASES; ph++) begin
            acc_re = 0;
            acc_im = 0;
            for (int t = 0; t < TAPS; t++) begin
                pos = (line_ptr + TAPS - t) % TAPS;
                acc_re += longint'(line_re[pos]) * longint'(kernel[ph + t * PHASES]);
                acc_im += longint'(line_im[pos]) * longint'(kernel[ph + t * PHASES]);
            end
            o.out_re      = round_to_q15(acc_re);
            o.out_im      = round_to_q15(acc_im);
            o.phase_index = phase_idx_t'(ph);
            o.last        = (ph == PHASES - 1);
            branch_outputs_due.push_back(o);
        end
        line_ptr = (line_ptr + 1) % TAPS;
    endfunction

    task automatic add_load(input int idx, input logic [15:0] val);
        interp_req_t r;
        r.command        = CMD_LOAD;
        r.coef_index     = coef_idx_t'(idx);
        r.coef_value     = coef_t'(val);
        r.sample_re      = sample_t'($urandom);
        r.sample_im      = sample_t'($urandom);
        r.wait_for_drain = 1'b0;
        r.no_gap         = calm_stretch;
        requests_todo.push_back(r);
        queued_total++;
    endtask

    task automatic add_push(input logic [15:0] re, input logic [15:0] im, input bit hold);
        interp_req_t r;
        r.command        = CMD_PUSH;
        r.coef_index     = coef_idx_t'($urandom);
        r.coef_value     = coef_t'($urandom);
        r.sample_re      = sample_t'(re);
        r.sample_im      = sample_t'(im);
        r.wait_for_drain = hold;
        r.no_gap         = calm_stretch;
        requests_todo.push_back(r);
        queued_total++;
    endtask

    always @(posedge aclk) begin : driver
        interp_req_t nxt;
        int          gap_left;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_request('{s_command, s_coef_index, s_coef_value,
                                  s_sample_re, s_sample_im, 1'b0, 1'b0});
                accepted_total++;
            end
            if (s_valid && !s_ready) begin
                // Hold the request until it is taken.
            end else if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (requests_todo.size() != 0 &&
                         !(requests_todo[0].wait_for_drain &&
                           branch_outputs_due.size() != 0)) begin
                nxt = requests_todo.pop_front();
                s_command    <= nxt.command;
                s_coef_index <= nxt.coef_index;
                s_coef_value <= nxt.coef_value;
                s_sample_re  <= nxt.sample_re;
                s_sample_im  <= nxt.sample_im;
                s_valid      <= 1'b1;
                gap_left = (nxt.no_gap || $urandom_range(0, 1)) ? 0 : gap_len();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin : receiver
        int stall_left;
        int mode_left;
        bit rx_calm;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left = 0;
            mode_left  = 0;
            rx_calm    = 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_calm   = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(200, 2000);
            end else begin
                mode_left--;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!rx_calm && $urandom_range(0, 99) < 30) begin
                stall_left = gap_len() - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : monitor
        branch_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (branch_outputs_due.size() == 0) begin
                $error("output with no request behind it: re %0d im %0d phase %0d",
                       m_out_re, m_out_im, m_phase_index);
                mismatch_count++;
            end else begin
                want = branch_outputs_due.pop_front();
                if (m_out_re !== want.out_re) begin
                    $error("m_out_re: expected %0d, got %0d", want.out_re, m_out_re);
                    mismatch_count++;
                end
                if (m_out_im !== want.out_im) begin
                    $error("m_out_im: expected %0d, got %0d", want.out_im, m_out_im);
                    mismatch_count++;
                end
                if (m_phase_index !== want.phase_index) begin
                    $error("m_phase_index: expected %0d, got %0d",
                           want.phase_index, m_phase_index);
                    mismatch_count++;
                end
                if (m_last !== want.last) begin
                    $error("m_last: expected %0d, got %0d", want.last, m_last);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[polyphase_interpolator] ERROR");
            $finish;
        end
    end

    initial begin
        int r;
        // The delay line starts out all zero, as after reset.
        for (int k = 0; k < TAPS; k++) begin
            line_re[k] = '0;
            line_im[k] = '0;
        end

        // Every coefficient is written before the first push reads the kernel.
        for (int k = 0; k < KERNEL_LEN; k++) add_load(k, 16'h8000);

        // Largest products of both signs drive the sums into saturation.
        add_push(16'h8000, 16'h7fff, 1'b0);
        add_push(16'h7fff, 16'h8000, 1'b0);
        add_push(16'h8000, 16'h8000, 1'b0);
        add_push(16'h8000, 16'h8000, 1'b0);
        add_push(16'h7fff, 16'h7fff, 1'b0);
        add_push(16'h7fff, 16'h7fff, 1'b0);
        add_push(16'h7fff, 16'h7fff, 1'b0);
        add_load(0, 16'h7fff);
        add_load(KERNEL_LEN - 1, 16'h7fff);
        add_load(5, 16'h0000);
        add_load(64, 16'h0001);
        add_push(16'h0000, 16'h0000, 1'b0);
        add_push(16'h0001, 16'hffff, 1'b0);
        add_push(16'h0000, 16'h0000, 1'b1);
        add_push(16'h4000, 16'hc000, 1'b0);

        calm_stretch = 1'b1;
        for (int k = 0; k < 32; k++) add_load($urandom_range(0, KERNEL_LEN - 1), pick_value());
        calm_stretch = 1'b0;

        for (int k = 0; k < 85; k++) begin
            if (k % 40 == 0) calm_stretch = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 30)
                add_load($urandom_range(0, KERNEL_LEN - 1), pick_value());
            else
                add_push(pick_value(), pick_value(), (k == 60));
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_total != queued_total) @(posedge aclk);
        while (branch_outputs_due.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);

        if (branch_outputs_due.size() != 0) begin
            $error("%0d outputs never arrived", branch_outputs_due.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("[polyphase_interpolator] OK");
        end else begin
            $display("[polyphase_interpolator] ERROR");
        end
        $finish;
    end

endmodule
